>>> design/fta_pkg.sv
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types and constants for the fan-out launch tree parent assignment.
// ----------------------------------------------------------------------------
package fta_pkg;

  localparam int unsigned MAX_HOSTS_DEF = 1024;
  localparam int unsigned TAG_BITS_DEF  = 16;

  localparam int unsigned WORK_W    = 11;
  localparam int unsigned GSIZE_W   = 10;
  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned OUT_TAG_W = 16;

  localparam logic [GSIZE_W-1:0] GSIZE_RESET = GSIZE_W'(50);
  localparam logic [WORK_W-1:0]  WORK_MAX    = '1;

  typedef struct packed {
    logic [OUT_TAG_W-1:0] host_tag;
    logic                 first_of_list;
  } fta_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] child_index;
    logic [OUT_TAG_W-1:0] child_tag;
    logic [OUT_IDX_W-1:0] parent_index;
    logic [OUT_TAG_W-1:0] parent_tag;
    logic                 is_root;
    logic                 table_full;
  } fta_out_t;

  // launcher table write strobes
  typedef struct packed {
    logic work_we;
    logic tag_we;
  } fta_wr_t;

  // scan unit control
  typedef struct packed {
    logic first;
    logic step;
  } fta_scan_t;

endpackage

>>> design/fta_table.sv
// ----------------------------------------------------------------------------
// fta_table
// Launcher table: work count and tag memories, one write and one registered
// read port each, sharing addresses.
// ----------------------------------------------------------------------------
module fta_table import fta_pkg::*; #(
  parameter int unsigned MAX_HOSTS = MAX_HOSTS_DEF,
  parameter int unsigned TAG_BITS  = TAG_BITS_DEF,
  localparam int unsigned IDX_W    = $clog2(MAX_HOSTS)
) (
  input  logic                clk,
  input  fta_wr_t             wr,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [WORK_W-1:0]   wr_work,
  input  logic [TAG_BITS-1:0] wr_tag,
  input  logic [IDX_W-1:0]    rd_addr,
  output logic [WORK_W-1:0]   rd_work,
  output logic [TAG_BITS-1:0] rd_tag
);

  logic [WORK_W-1:0]   work_mem [MAX_HOSTS];
  logic [TAG_BITS-1:0] tag_mem  [MAX_HOSTS];

  always_ff @(posedge clk) begin
    if (wr.work_we) begin
      work_mem[wr_addr] <= wr_work;
    end
    rd_work <= work_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.tag_we) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    rd_tag <= tag_mem[rd_addr];
  end

endmodule

>>> design/fta_scan.sv
// ----------------------------------------------------------------------------
// fta_scan
// Parent pick unit: one launcher per step, keeps the index with the lowest
// work plus index (earliest on ties).
// ----------------------------------------------------------------------------
module fta_scan import fta_pkg::*; #(
  parameter int unsigned MAX_HOSTS = MAX_HOSTS_DEF,
  localparam int unsigned IDX_W    = $clog2(MAX_HOSTS),
  localparam int unsigned KEY_W    = ((WORK_W > IDX_W) ? WORK_W : IDX_W) + 1
) (
  input  logic              clk,
  input  fta_scan_t         ctl,
  input  logic [IDX_W-1:0]  index,
  input  logic [WORK_W-1:0] work,
  output logic [IDX_W-1:0]  best
);

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] cand;
  logic [IDX_W-1:0] best_r;

  // work[a] - (i - a) > work[i]  <=>  work[a] + a > work[i] + i
  assign cand = KEY_W'(work) + KEY_W'(index);
  assign best = best_r;

  always_ff @(posedge clk) begin
    if (ctl.first) begin
      best_r <= index;
      key_r  <= cand;
    end else if (ctl.step && (key_r > cand)) begin
      best_r <= index;
      key_r  <= cand;
    end
  end

endmodule

>>> design/fanout_tree_parent_assign.sv
// ----------------------------------------------------------------------------
// fanout_tree_parent_assign
// Fan-out launch tree builder: assigns each host of a list a launcher index
// and a parent launcher, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// One transaction at a time. A root host passes through S_ROOT and S_OUT,
// a dropped host (table full) only through S_OUT, and a host inside a group
// through S_RD, S_UPD and S_OUT. The result register loads in the same cycle
// that the input is free again, and a result still stalled on the output
// holds the block in its last state until it leaves. The first host of each
// group also runs the parent scan (S_SCAN_INIT, S_SCAN, S_PICK), which reads
// the work memory one launcher per cycle through its single read port. The
// table memories are not cleared; a new list resets the launcher count, the
// group position and the parent.
// ----------------------------------------------------------------------------
module fanout_tree_parent_assign import fta_pkg::*; #(
  parameter int unsigned MAX_HOSTS = MAX_HOSTS_DEF,
  parameter int unsigned TAG_BITS  = TAG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fta_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fta_out_t           out_data,
  input  logic               cfg_we,
  input  logic [GSIZE_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(MAX_HOSTS);
  localparam int unsigned CNT_W = $clog2(MAX_HOSTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ROOT, S_SCAN_INIT, S_SCAN, S_PICK, S_RD, S_UPD, S_OUT
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  logic [GSIZE_W-1:0]  gpos_r;
  logic [GSIZE_W-1:0]  gsize_r;
  logic [IDX_W-1:0]    parent_r;
  logic [IDX_W-1:0]    iss_r;
  logic [IDX_W-1:0]    chk_r;
  logic [IDX_W-1:0]    idx_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [TAG_BITS-1:0] ptag_r;
  logic                root_r;
  logic                full_r;
  logic                out_valid_r;
  fta_out_t            out_r;

  fta_wr_t             wr;
  logic [IDX_W-1:0]    wr_addr;
  logic [WORK_W-1:0]   wr_work;
  logic [IDX_W-1:0]    rd_addr;
  logic [WORK_W-1:0]   rd_work;
  logic [TAG_BITS-1:0] rd_tag;
  fta_scan_t           scan_ctl;
  logic [IDX_W-1:0]    best;

  logic                in_acc;
  logic                is_root_in;
  logic                scan_done;
  logic [GSIZE_W-1:0]  gsize_eff;
  logic [GSIZE_W-1:0]  gpos_nxt;
  fta_out_t            res;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_root_in = in_data.first_of_list || (count_r == '0);
  assign scan_done  = (CNT_W'(chk_r) == (count_r - CNT_W'(1)));
  assign gsize_eff  = (gsize_r == '0) ? GSIZE_W'(1) : gsize_r;
  assign gpos_nxt   = ((GSIZE_W + 1)'(gpos_r) + (GSIZE_W + 1)'(1) >= (GSIZE_W + 1)'(gsize_eff))
                      ? '0 : gpos_r + GSIZE_W'(1);

  always_comb begin
    wr       = '0;
    wr_addr  = idx_r;
    wr_work  = '0;
    rd_addr  = parent_r;
    unique case (state_r)
      S_ROOT: begin
        wr.work_we = 1'b1;
        wr.tag_we  = 1'b1;
        wr_addr    = '0;
      end
      S_SCAN_INIT: begin
        rd_addr = '0;
      end
      S_SCAN: begin
        rd_addr = iss_r;
      end
      S_RD: begin
        wr.work_we = 1'b1;
        wr.tag_we  = 1'b1;
      end
      S_UPD: begin
        wr.work_we = 1'b1;
        wr_addr    = parent_r;
        wr_work    = (rd_work == WORK_MAX) ? rd_work : rd_work + WORK_W'(1);
      end
      default: ;
    endcase
  end

  assign scan_ctl.step  = (state_r == S_SCAN);
  assign scan_ctl.first = (state_r == S_SCAN) && (chk_r == '0);

  always_comb begin
    res           = '0;
    res.child_tag = OUT_TAG_W'(tag_r);
    if (root_r) begin
      res.is_root = 1'b1;
    end else if (full_r) begin
      res.table_full = 1'b1;
    end else begin
      res.child_index  = OUT_IDX_W'(idx_r);
      res.parent_index = OUT_IDX_W'(parent_r);
      res.parent_tag   = OUT_TAG_W'(ptag_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      gpos_r      <= '0;
      gsize_r     <= GSIZE_RESET;
      parent_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        gsize_r <= cfg_wdata;
      end
      if (!out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            tag_r  <= TAG_BITS'(in_data.host_tag);
            idx_r  <= count_r[IDX_W-1:0];
            root_r <= is_root_in;
            full_r <= !is_root_in && (count_r == CNT_W'(MAX_HOSTS));
            if (is_root_in) begin
              state_r <= S_ROOT;
            end else if (count_r == CNT_W'(MAX_HOSTS)) begin
              state_r <= S_OUT;
            end else if (gpos_r == '0) begin
              state_r <= S_SCAN_INIT;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_ROOT: begin
          count_r  <= CNT_W'(1);
          gpos_r   <= '0;
          parent_r <= '0;
          state_r  <= S_OUT;
        end
        S_SCAN_INIT: begin
          iss_r   <= IDX_W'(1);
          chk_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          chk_r <= iss_r;
          iss_r <= iss_r + IDX_W'(1);
          if (scan_done) begin
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          parent_r <= best;
          state_r  <= S_RD;
        end
        S_RD: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          ptag_r  <= rd_tag;
          count_r <= count_r + CNT_W'(1);
          gpos_r  <= gpos_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_r       <= res;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  fta_table #(
    .MAX_HOSTS (MAX_HOSTS),
    .TAG_BITS  (TAG_BITS)
  ) u_table (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_work (wr_work),
    .wr_tag  (tag_r),
    .rd_addr (rd_addr),
    .rd_work (rd_work),
    .rd_tag  (rd_tag)
  );

  fta_scan #(
    .MAX_HOSTS (MAX_HOSTS)
  ) u_scan (
    .clk   (clk),
    .ctl   (scan_ctl),
    .index (chk_r),
    .work  (rd_work),
    .best  (best)
  );

endmodule

>>> design/fta_checker.sv
// ----------------------------------------------------------------------------
// fta_checker
// Port-level checks for the launch tree block, bound to the top level.
// ----------------------------------------------------------------------------
module fta_checker import fta_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input fta_out_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_root && out_data.table_full))
    else $error("root and full flagged together");

  a_root_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_root |->
      out_data.child_index == '0 && out_data.parent_index == '0 &&
      out_data.parent_tag == '0)
    else $error("root result carries index or parent");

endmodule

bind fanout_tree_parent_assign fta_checker u_fta_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> verif/tb_fanout_tree_parent_assign.sv
// ----------------------------------------------------------------------------
// tb_fanout_tree_parent_assign
// Self-checking bench for the fan-out launch tree builder. Host lists are
// driven in random bursts while the result side stalls on its own pattern. A
// local model of the launcher table predicts each result transaction, which
// is compared field by field. The group size changes between phases while
// the block is idle. The phases cover the root cases, a zero group size, a
// table that fills up and drops hosts, and random lists of mixed length.
// ----------------------------------------------------------------------------
module tb_fanout_tree_parent_assign;
  timeunit 1ns;
  timeprecision 1ps;

  import fta_pkg::*;

  localparam int unsigned HOSTS     = MAX_HOSTS_DEF;
  localparam int unsigned MIN_HOSTS = 1600;

  typedef enum int unsigned {RX_FREE, RX_COIN, RX_BUSY, RX_TOGGLE} rx_mode_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  fta_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fta_out_t           out_data;
  logic               cfg_we    = 1'b0;
  logic [GSIZE_W-1:0] cfg_wdata = '0;

  fanout_tree_parent_assign DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // launcher table model
  logic [WORK_W-1:0]    launch_work [HOSTS];
  logic [OUT_TAG_W-1:0] launch_tag  [HOSTS];
  int unsigned          launch_count  = 0;
  int unsigned          launch_parent = 0;
  int unsigned          group_pos     = 0;
  logic [GSIZE_W-1:0]   group_len     = GSIZE_RESET;

  fta_in_t     hosts_to_send[$];
  fta_out_t    assignments_due[$];
  int unsigned errors       = 0;
  int unsigned hosts_queued = 0;
  bit          in_pending   = 1'b0;
  int          burst_left   = 4;
  int          gap_left     = 0;
  rx_mode_t    rx_mode      = RX_FREE;
  int          rx_left      = 0;

  function automatic void assign_parent(fta_in_t h);
    fta_out_t r;
    int       best;
    r = '0;
    r.child_tag = h.host_tag;
    if (h.first_of_list || launch_count == 0) begin
      launch_tag[0]  = h.host_tag;
      launch_work[0] = '0;
      launch_count   = 1;
      launch_parent  = 0;
      group_pos      = 0;
      r.is_root      = 1'b1;
    end else if (launch_count >= HOSTS) begin
      r.table_full = 1'b1;
    end else begin
      if (group_pos == 0) begin
        best = 0;
        for (int i = 1; i < int'(launch_count); i++)
          if (int'(launch_work[best]) - (i - best) > int'(launch_work[i]))
            best = i;
        launch_parent = best;
      end
      launch_tag[launch_count]  = h.host_tag;
      launch_work[launch_count] = '0;
      if (launch_work[launch_parent] != WORK_MAX)
        launch_work[launch_parent] = launch_work[launch_parent] + 1'b1;
      r.child_index  = OUT_IDX_W'(launch_count);
      r.parent_index = OUT_IDX_W'(launch_parent);
      r.parent_tag   = launch_tag[launch_parent];
      launch_count++;
      group_pos++;
      if (group_pos >= ((group_len == 0) ? 1 : group_len))
        group_pos = 0;
    end
    assignments_due.push_back(r);
  endfunction

  function automatic void report(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 200)
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  // monitor: checks results, then books newly accepted hosts
  always @(posedge clk) begin
    fta_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (assignments_due.size() == 0) begin
          errors++;
          if (errors <= 200)
            $display("%0t ns: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = assignments_due.pop_front();
          if (out_data.child_index !== want.child_index)
            report("child_index", want.child_index, out_data.child_index);
          if (out_data.child_tag !== want.child_tag)
            report("child_tag", want.child_tag, out_data.child_tag);
          if (out_data.parent_index !== want.parent_index)
            report("parent_index", want.parent_index, out_data.parent_index);
          if (out_data.parent_tag !== want.parent_tag)
            report("parent_tag", want.parent_tag, out_data.parent_tag);
          if (out_data.is_root !== want.is_root)
            report("is_root", want.is_root, out_data.is_root);
          if (out_data.table_full !== want.table_full)
            report("table_full", want.table_full, out_data.table_full);
        end
      end
      if (in_valid && !in_stall) begin
        in_pending = 1'b0;
        assign_parent(in_data);
      end
    end
  end

  // driver: bursts of transactions with random gaps
  always @(negedge clk) begin
    if (rst_n && !in_pending) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (hosts_to_send.size() != 0) begin
        in_data    <= hosts_to_send.pop_front();
        in_valid   <= 1'b1;
        in_pending = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall pattern
  always @(negedge clk) begin
    if (rx_left <= 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE: begin
        out_stall <= 1'b0;
      end
      RX_COIN: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      RX_BUSY: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall <= ~out_stall;
      end
    endcase
  end

  function automatic void queue_host(logic [OUT_TAG_W-1:0] tag, logic first);
    fta_in_t h;
    h.host_tag      = tag;
    h.first_of_list = first;
    hosts_to_send.push_back(h);
    hosts_queued++;
  endfunction

  function automatic logic [OUT_TAG_W-1:0] rand_tag();
    return OUT_TAG_W'($urandom_range(0, 65535));
  endfunction

  // mostly well-formed lists; some continue the previous list or restart early
  function automatic void queue_list(int len);
    queue_host(rand_tag(), $urandom_range(0, 9) != 0);
    for (int i = 1; i < len; i++)
      queue_host(rand_tag(), $urandom_range(0, 39) == 0);
  endfunction

  task automatic wait_drained();
    while (hosts_to_send.size() != 0 || in_pending || assignments_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_group_len(logic [GSIZE_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    group_len = v;
  endtask

  function automatic logic [GSIZE_W-1:0] rand_group_len();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5)
      return GSIZE_W'($urandom_range(1, 6));
    else if (pick <= 7)
      return GSIZE_W'($urandom_range(7, 40));
    else if (pick == 8)
      return '0;
    else
      return GSIZE_W'($urandom_range(41, 1023));
  endfunction

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset group size; first host arrives before any list
    queue_host(16'hFFFF, 1'b0);
    queue_host(16'h0000, 1'b0);
    queue_host(16'hFFFF, 1'b0);
    queue_host(16'h8001, 1'b0);
    queue_host(16'h7FFE, 1'b0);
    queue_host(16'h0000, 1'b1);
    repeat (5) queue_host(rand_tag(), 1'b0);
    queue_host(16'hA5A5, 1'b1);
    queue_host(16'h5A5A, 1'b0);

    // zero group size behaves as one
    write_group_len('0);
    queue_host(16'h1234, 1'b1);
    repeat (11) queue_host(rand_tag(), 1'b0);

    // fill the table, then overflow it
    write_group_len(GSIZE_W'($urandom_range(100, 300)));
    queue_host(rand_tag(), 1'b1);
    repeat (HOSTS - 1) queue_host(rand_tag(), 1'b0);
    queue_host(16'hFFFF, 1'b0);
    queue_host(16'h0000, 1'b0);
    queue_host(rand_tag(), 1'b0);

    write_group_len('1);
    queue_host(rand_tag(), 1'b1);
    repeat (60) queue_host(rand_tag(), 1'b0);

    write_group_len(GSIZE_W'(1));
    queue_host(rand_tag(), 1'b1);
    repeat (40) queue_host(rand_tag(), 1'b0);

    while (hosts_queued < MIN_HOSTS) begin
      write_group_len(rand_group_len());
      repeat ($urandom_range(2, 5)) queue_list($urandom_range(1, 90));
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (errors == 0)
      $display("** fanout_tree_parent_assign: PASSED **");
    else
      $display("** fanout_tree_parent_assign: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout at %0t ns", $time);
    $display("** fanout_tree_parent_assign: FAILED **");
    $finish;
  end

endmodule
